// ----- rtl/dbs_pkg.sv -----
// ----------------------------------------------------------------------------
// Directory block byte swapper package
// Shared widths, register indexes, configuration type and the byte swaps.
// ----------------------------------------------------------------------------
package dbs_pkg;

  localparam int WORD_W    = 32;
  localparam int OFF_W     = 17;
  localparam int LEN_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 17;

  localparam logic [OFF_W-1:0] BLOCK_SIZE_RST = 17'd512;
  localparam logic [OFF_W-1:0] OFFSET_MAX     = 17'h1FFFC;
  localparam logic [OFF_W-1:0] HDR_BYTES      = 17'd8;
  localparam logic [OFF_W-1:0] WORD_BYTES     = 17'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_SIZE = 1'b0,
    REG_WRITE_PASS = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [OFF_W-1:0] block_size;
    logic             write_pass;
  } cfg_t;

  function automatic logic [WORD_W-1:0] reverse_bytes(input logic [WORD_W-1:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  function automatic logic [WORD_W-1:0] swap_halves(input logic [WORD_W-1:0] w);
    return {w[23:16], w[31:24], w[7:0], w[15:8]};
  endfunction

endpackage

// ----- rtl/directory_block_byte_swapper_core.sv -----
// ----------------------------------------------------------------------------
// Directory block byte swapper
// Converts the byte order of directory record headers in a word stream.
// ----------------------------------------------------------------------------
// An accepted input word passes through the input register and then the result register.
// Throughput: one word per cycle while out_ready is high, set by the input and result registers.
// Reset: synchronous, active low; empties both stages, block_size returns to
// 512, write_pass to 0, and the walk starts as at a block start.
module directory_block_byte_swapper_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dbs_pkg::WORD_W-1:0]    in_word_in,
  input  logic                          in_block_start,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dbs_pkg::WORD_W-1:0]    out_word_out,
  output logic                          out_walk_stopped,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dbs_pkg::CFG_DAT_W-1:0] cfg_data
);
  import dbs_pkg::*;

  cfg_t              cfg_r;
  logic              s1_valid_r;
  logic [WORD_W-1:0] s1_word_r;
  logic              s1_start_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_word_r;
  logic              out_stop_r;

  logic              s1_adv;
  logic              in_fire;
  logic [WORD_W-1:0] res_word;
  logic              res_stopped;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.block_size <= BLOCK_SIZE_RST;
      cfg_r.write_pass <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BLOCK_SIZE: cfg_r.block_size <= cfg_data[OFF_W-1:0];
        REG_WRITE_PASS: cfg_r.write_pass <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The input stage moves on whenever the result register is free or drained.
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_word_r  <= in_word_in;
      s1_start_r <= in_block_start;
    end
  end

  dbs_walk u_walk (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (s1_adv),
    .word        (s1_word_r),
    .blk_start   (s1_start_r),
    .cfg         (cfg_r),
    .res_word    (res_word),
    .res_stopped (res_stopped)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_word_r <= res_word;
      out_stop_r <= res_stopped;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_word_out     = out_word_r;
  assign out_walk_stopped = out_stop_r;

endmodule

// ----- rtl/dbs_walk.sv -----
// ----------------------------------------------------------------------------
// Directory record walker
// Tracks the record headers of a block and converts each word accordingly.
// ----------------------------------------------------------------------------
module dbs_walk (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic [dbs_pkg::WORD_W-1:0] word,
  input  logic                       blk_start,
  input  dbs_pkg::cfg_t              cfg,
  output logic [dbs_pkg::WORD_W-1:0] res_word,
  output logic                       res_stopped
);
  import dbs_pkg::*;

  logic [OFF_W-1:0]  byte_offset_r, byte_offset_nxt;
  logic [OFF_W-1:0]  next_header_r, next_header_nxt;
  logic              stopped_r, stopped_nxt;

  logic [OFF_W-1:0]  off;
  logic [OFF_W-1:0]  nh;
  logic              stp;
  logic              at_hdr0;
  logic              at_hdr1;
  logic [WORD_W-1:0] rev_word;
  logic [WORD_W-1:0] sw_word;
  logic [LEN_W-1:0]  rec_len;
  logic [OFF_W:0]    nh_sum;
  logic              len_bad;
  logic              tail_short;

  // A block start clears the walk before the word is looked at.
  assign off = blk_start ? '0 : byte_offset_r;
  assign nh  = blk_start ? '0 : next_header_r;
  assign stp = blk_start ? 1'b0 : stopped_r;

  assign at_hdr0 = (off == nh);
  assign at_hdr1 = ({1'b0, off} == ({1'b0, nh} + {1'b0, WORD_BYTES}));

  assign rev_word = reverse_bytes(word);
  assign sw_word  = swap_halves(word);
  assign rec_len  = cfg.write_pass ? word[LEN_W-1:0] : sw_word[LEN_W-1:0];
  assign nh_sum   = {1'b0, nh} + {{(OFF_W+1-LEN_W){1'b0}}, rec_len};
  assign len_bad  = (rec_len < LEN_W'(8)) || (rec_len[1:0] != 2'b00) ||
                    (nh_sum > {1'b0, cfg.block_size});
  assign tail_short = (({1'b0, off} + {1'b0, HDR_BYTES}) > {1'b0, cfg.block_size});

  always_comb begin
    res_word        = word;
    stopped_nxt     = stp;
    next_header_nxt = nh;
    if (!stp) begin
      if (at_hdr0) begin
        if (tail_short) begin
          stopped_nxt = 1'b1;
        end else begin
          res_word = rev_word;
        end
      end else if (at_hdr1) begin
        res_word = sw_word;
        if (len_bad) begin
          stopped_nxt = 1'b1;
        end else begin
          next_header_nxt = nh_sum[OFF_W-1:0];
        end
      end
    end
    byte_offset_nxt = (off < OFFSET_MAX) ? (off + WORD_BYTES) : off;
  end

  assign res_stopped = stopped_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_offset_r <= '0;
      next_header_r <= '0;
      stopped_r     <= 1'b0;
    end else if (step) begin
      byte_offset_r <= byte_offset_nxt;
      next_header_r <= next_header_nxt;
      stopped_r     <= stopped_nxt;
    end
  end

endmodule

// ----- rtl/dbs_checker.sv -----
// ----------------------------------------------------------------------------
// Directory block byte swapper checker
// Port-level assertions on the swapper, attached to the top level by bind.
// ----------------------------------------------------------------------------
module dbs_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [dbs_pkg::WORD_W-1:0]    out_word_out,
  input  logic                          out_walk_stopped
);

  // A result word that is not taken holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word_out) &&
                                $stable(out_walk_stopped))
    else $error("result word changed while stalled");

  // Nothing comes out in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // With the result side draining, an accepted word passes the input register and reaches the output.
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && out_ready) ##1 out_ready |=> out_valid)
    else $error("accepted word did not reach the output");

  // The swapper never stalls its input while both stages are draining.
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready && $past(out_ready) && $past(rst_n) |-> in_ready)
    else $error("input stalled with a free pipeline");

endmodule

bind directory_block_byte_swapper_core dbs_checker u_dbs_checker (.*);
